// ----- src/bfmd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmd_pkg: shared constants and types of the 2x2 box-filter mip downscaler
// Holds the size limits, register indexes and the packed pair-sum layout.
// ----------------------------------------------------------------------------
package bfmd_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;

	localparam int DIM_W   = 13;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int LINE_AW = $clog2(LINE_DEPTH);
	localparam int CMP_W   = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;

	localparam int CHAN_W = 8;
	localparam int PAIR_W = 9;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic REG_SOURCE_WIDTH  = 1'b0;
	localparam logic REG_SOURCE_HEIGHT = 1'b1;

	typedef struct packed {
		logic [PAIR_W-1:0] alpha;
		logic [PAIR_W-1:0] red;
		logic [PAIR_W-1:0] green;
		logic [PAIR_W-1:0] blue;
	} pair_t;

	localparam int ENTRY_W = $bits(pair_t);

endpackage

// ----- src/bfmd_line_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmd_line_ram: simple dual-port line buffer
// One write port and one read port; read data is registered on a read.
// ----------------------------------------------------------------------------
module bfmd_line_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/box_filter_mip_downscale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_mip_downscale: one pass of a 2x2 box-filter mipmap reduction
// Source ARGB8888 pixels enter in raster order on a valid/ready channel and
// each completed 2x2 block leaves as one rounded-mean pixel of the next level.
//
// The source size is set over the APB port (source_width at 0x0,
// source_height at 0x4); a write restarts the pass at the first pixel.
// A pixel is accepted on every cycle while the output register is free or
// being drained, so the block sustains one source pixel per clock while the receiver keeps up.
// Horizontal pair sums of even rows wait in a 2048-entry line buffer with
// a registered read port; an odd-row pair reads its partner there.
// A result passes the line-buffer read stage and then the output register
// after the transfer of the pixel that completes its block.
// level_done marks the last pixel of the output level.
// When the receiver stalls, the pending result holds and in_ready drops
// once both the read stage and the output register are occupied.
// Reset sets both dimensions to 1 and the position to the first pixel;
// the line buffer is not cleared, as each entry is written before it is read.
// ----------------------------------------------------------------------------
module box_filter_mip_downscale (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bfmd_pkg::APB_AW-1:0]    paddr,
	input  logic [bfmd_pkg::APB_DW-1:0]    pwdata,
	output logic [bfmd_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bfmd_pkg::CHAN_W-1:0]    alpha_in,
	input  logic [bfmd_pkg::CHAN_W-1:0]    red_in,
	input  logic [bfmd_pkg::CHAN_W-1:0]    green_in,
	input  logic [bfmd_pkg::CHAN_W-1:0]    blue_in,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bfmd_pkg::CHAN_W-1:0]    alpha_out,
	output logic [bfmd_pkg::CHAN_W-1:0]    red_out,
	output logic [bfmd_pkg::CHAN_W-1:0]    green_out,
	output logic [bfmd_pkg::CHAN_W-1:0]    blue_out,
	output logic                           level_done
);

	localparam int DIM_W   = bfmd_pkg::DIM_W;
	localparam int COL_W   = bfmd_pkg::COL_W;
	localparam int ROW_W   = bfmd_pkg::ROW_W;
	localparam int CMP_W   = bfmd_pkg::CMP_W;
	localparam int CHAN_W  = bfmd_pkg::CHAN_W;
	localparam int PAIR_W  = bfmd_pkg::PAIR_W;
	localparam int LINE_AW = bfmd_pkg::LINE_AW;
	localparam int SUM_W   = PAIR_W + 1;

	function automatic logic [CHAN_W-1:0] round_mean(input logic [PAIR_W-1:0] a,
		input logic [PAIR_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = {1'b0, a} + {1'b0, b} + SUM_W'(2);
		return s[SUM_W-1:2];
	endfunction

	function automatic logic [PAIR_W-1:0] chan_add(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		return {1'b0, a} + {1'b0, b};
	endfunction

	// Configuration registers.
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] wr_val;
	logic             cfg_wr;
	logic             cfg_sel_height;

	assign pready         = 1'b1;
	assign cfg_wr         = psel && penable && pwrite;
	assign wr_val         = pwdata[DIM_W-1:0];
	assign cfg_sel_height = (paddr[2] == bfmd_pkg::REG_SOURCE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg_wr) begin
			if (!cfg_sel_height) begin
				if (wr_val == '0) begin
					width_q <= DIM_W'(1);
				end else if (CMP_W'(wr_val) > CMP_W'(bfmd_pkg::MAX_WIDTH)) begin
					width_q <= DIM_W'(bfmd_pkg::MAX_WIDTH);
				end else begin
					width_q <= wr_val;
				end
			end else begin
				if (wr_val == '0) begin
					height_q <= DIM_W'(1);
				end else if (CMP_W'(wr_val) > CMP_W'(bfmd_pkg::MAX_HEIGHT)) begin
					height_q <= DIM_W'(bfmd_pkg::MAX_HEIGHT);
				end else begin
					height_q <= wr_val;
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[2])
			bfmd_pkg::REG_SOURCE_WIDTH:  prdata = bfmd_pkg::APB_DW'(width_q);
			bfmd_pkg::REG_SOURCE_HEIGHT: prdata = bfmd_pkg::APB_DW'(height_q);
			default:                     prdata = '0;
		endcase
	end

	// Position and accept-stage decode.
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	bfmd_pkg::pair_t       held_q;
	logic                  w_one, h_one;
	logic                  col_ok, row_ok, col_last, row_last;
	logic                  have_pair, mem_we, mem_re, emit;
	logic [CMP_W-1:0]      x_ext, y_ext, w_ext, h_ext, x_inc, y_inc;
	bfmd_pkg::pair_t       pair;
	logic [LINE_AW-1:0]    line_addr;
	logic                  in_fire;

	assign w_one = (width_q == DIM_W'(1));
	assign h_one = (height_q == DIM_W'(1));
	assign x_ext = CMP_W'(col_q);
	assign y_ext = CMP_W'(row_q);
	assign w_ext = CMP_W'(width_q);
	assign h_ext = CMP_W'(height_q);
	assign x_inc = x_ext + CMP_W'(1);
	assign y_inc = y_ext + CMP_W'(1);

	assign col_ok = w_one ? (col_q == '0) : (x_ext < (w_ext & ~CMP_W'(1)));
	assign row_ok = h_one ? (row_q == '0) : (y_ext < (h_ext & ~CMP_W'(1)));
	assign col_last = w_one ||
		(CMP_W'(col_q[COL_W-1:1]) == CMP_W'(width_q[DIM_W-1:1]) - CMP_W'(1));
	assign row_last = h_one ||
		(CMP_W'(row_q[ROW_W-1:1]) == CMP_W'(height_q[DIM_W-1:1]) - CMP_W'(1));

	assign have_pair = col_ok && row_ok && (w_one || col_q[0]);
	assign mem_we    = in_fire && have_pair && !h_one && !row_q[0];
	assign mem_re    = in_fire && have_pair && !h_one && row_q[0];
	assign emit      = have_pair && (h_one || row_q[0]);
	assign line_addr = w_one ? '0 : col_q[COL_W-1:1];

	always_comb begin
		if (w_one) begin
			pair.alpha = chan_add(alpha_in, alpha_in);
			pair.red   = chan_add(red_in, red_in);
			pair.green = chan_add(green_in, green_in);
			pair.blue  = chan_add(blue_in, blue_in);
		end else begin
			pair.alpha = chan_add(held_q.alpha[CHAN_W-1:0], alpha_in);
			pair.red   = chan_add(held_q.red[CHAN_W-1:0], red_in);
			pair.green = chan_add(held_q.green[CHAN_W-1:0], green_in);
			pair.blue  = chan_add(held_q.blue[CHAN_W-1:0], blue_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (col_ok && row_ok && !w_one && !col_q[0]) begin
				held_q <= '{alpha: {1'b0, alpha_in}, red: {1'b0, red_in},
					green: {1'b0, green_in}, blue: {1'b0, blue_in}};
			end
			if (x_inc >= w_ext) begin
				col_q <= '0;
				if (y_inc >= h_ext) begin
					row_q <= '0;
				end else begin
					row_q <= y_inc[ROW_W-1:0];
				end
			end else begin
				col_q <= x_inc[COL_W-1:0];
			end
		end
	end

	// Line buffer of even-row pair sums.
	logic [bfmd_pkg::ENTRY_W-1:0] line_rdata;
	bfmd_pkg::pair_t              other;

	bfmd_line_ram #(
		.DEPTH(bfmd_pkg::LINE_DEPTH),
		.WIDTH(bfmd_pkg::ENTRY_W)
	) u_line_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (line_addr),
		.wdata (pair),
		.re    (mem_re),
		.raddr (line_addr),
		.rdata (line_rdata)
	);

	// Read stage: waits for the line-buffer data.
	logic            valid_s1, use_mem_s1, done_s1;
	bfmd_pkg::pair_t pair_s1;
	logic            out_valid_q, done_q;
	logic [CHAN_W-1:0] alpha_q, red_q, green_q, blue_q;
	logic            adv_out;

	assign adv_out  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_out;
	assign in_fire  = in_valid && in_ready;
	assign other    = use_mem_s1 ? bfmd_pkg::pair_t'(line_rdata) : pair_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= emit;
		end else if (adv_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			pair_s1    <= pair;
			use_mem_s1 <= !h_one;
			done_s1    <= col_last && row_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			alpha_q <= round_mean(pair_s1.alpha, other.alpha);
			red_q   <= round_mean(pair_s1.red, other.red);
			green_q <= round_mean(pair_s1.green, other.green);
			blue_q  <= round_mean(pair_s1.blue, other.blue);
			done_q  <= done_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign alpha_out  = alpha_q;
	assign red_out    = red_q;
	assign green_out  = green_q;
	assign blue_out   = blue_q;
	assign level_done = done_q;

	// The line buffer never reads and writes on the same pixel.
	assert property (@(posedge clk) disable iff (!arst_n) !(mem_we && mem_re))
		else $error("line buffer read and write at once");

	// Input stalls only when both the read stage and the output are full.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled with room in the pipeline");

	// An odd-row pair lands in the read stage marked to use the line buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (valid_s1 && use_mem_s1))
		else $error("line buffer read lost");

	// The column position stays inside the source width.
	assert property (@(posedge clk) disable iff (!arst_n) x_ext < w_ext)
		else $error("column position out of range");

	// A completed result that cannot leave keeps the read stage occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_out) |=> valid_s1)
		else $error("read stage dropped a stalled result");

endmodule
